>>> rtl/lpct_pkg.sv
// ============================================================================
// lpct_pkg
// Shared types and constants for the LRU page cache tracker.
// ============================================================================
package lpct_pkg;

    localparam int LPCT_CACHE_ENTRIES = 16;
    localparam int LPCT_PAGE_W        = 32;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_EVICT = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_DONE
    } lpct_state_t;

    typedef struct packed {
        logic [1:0]             command;
        logic [LPCT_PAGE_W-1:0] page_number;
    } lpct_in_t;

    typedef struct packed {
        logic                   hit;
        logic                   fetch_needed;
        logic                   writeback_valid;
        logic [LPCT_PAGE_W-1:0] writeback_page;
        logic                   empty_error;
    } lpct_out_t;

endpackage

>>> rtl/lpct_page_ram.sv
// ============================================================================
// lpct_page_ram
// Page list memory indexed by recency rank: one write port, one read port,
// read data registered.
// ============================================================================
module lpct_page_ram #(
    parameter int DEPTH = lpct_pkg::LPCT_CACHE_ENTRIES
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [lpct_pkg::LPCT_PAGE_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [lpct_pkg::LPCT_PAGE_W-1:0] rd_data
);
    import lpct_pkg::*;

    logic [LPCT_PAGE_W-1:0] page_mem [DEPTH];
    logic [LPCT_PAGE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            page_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= page_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/lpct_ctrl.sv
// ============================================================================
// lpct_ctrl
// Sequencer for the recency list: walks the list from most recent entry,
// shifting each entry down one rank while it searches for the page.
// ============================================================================
module lpct_ctrl #(
    parameter int CACHE_ENTRIES = lpct_pkg::LPCT_CACHE_ENTRIES
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  lpct_pkg::lpct_in_t                       s_data,
    output logic                                     res_valid,
    input  logic                                     res_ready,
    output lpct_pkg::lpct_out_t                      res,
    output logic                                     wr_en,
    output logic [$clog2(CACHE_ENTRIES)-1:0]         wr_addr,
    output logic [lpct_pkg::LPCT_PAGE_W-1:0]         wr_data,
    output logic                                     rd_en,
    output logic [$clog2(CACHE_ENTRIES)-1:0]         rd_addr,
    input  logic [lpct_pkg::LPCT_PAGE_W-1:0]         rd_data
);
    import lpct_pkg::*;

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(CACHE_ENTRIES);

    lpct_state_t            state_reg, state_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [LPCT_PAGE_W-1:0] carry_reg, carry_next;
    logic [LPCT_PAGE_W-1:0] page_reg, page_next;
    logic [1:0]             cmd_reg, cmd_next;
    lpct_out_t              res_reg, res_next;
    logic                   accept;
    logic                   list_end;
    logic                   match;

    assign accept   = s_valid && s_ready;
    assign list_end = (idx_reg == count_reg);
    assign match    = (rd_data == page_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.command) inside
                        CMD_READ, CMD_WRITE: state_next = ST_SCAN;
                        CMD_EVICT: state_next = (count_reg == '0) ? ST_DONE : ST_EVICT;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (list_end || match) begin
                    state_next = ST_DONE;
                end
            end
            ST_EVICT: state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        idx_next   = idx_reg;
        count_next = count_reg;
        carry_next = carry_reg;
        page_next  = page_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = carry_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next   = s_data.command;
                    page_next  = s_data.page_number;
                    carry_next = s_data.page_number;
                    idx_next   = '0;
                    res_next   = '0;
                    case (s_data.command) inside
                        CMD_READ, CMD_WRITE: begin
                            rd_en = 1'b1;
                        end
                        CMD_EVICT: begin
                            if (count_reg == '0) begin
                                res_next.empty_error = 1'b1;
                            end else begin
                                // least recent entry sits at the last rank
                                rd_en   = 1'b1;
                                rd_addr = AW'(count_reg - CW'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (list_end) begin
                    res_next.fetch_needed = (cmd_reg == CMD_READ);
                    if (count_reg == FULL) begin
                        // carried entry fell off the end of the list
                        res_next.writeback_valid = 1'b1;
                        res_next.writeback_page  = carry_reg;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end else begin
                    // shift: this rank takes the entry from the rank above
                    wr_en = 1'b1;
                    if (match) begin
                        res_next.hit = 1'b1;
                    end else begin
                        carry_next = rd_data;
                        idx_next   = idx_reg + CW'(1);
                        rd_en      = 1'b1;
                        rd_addr    = AW'(idx_reg + CW'(1));
                    end
                end
            end
            ST_EVICT: begin
                res_next.writeback_valid = 1'b1;
                res_next.writeback_page  = rd_data;
                count_next               = count_reg - CW'(1);
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg   <= idx_next;
        carry_reg <= carry_next;
        page_reg  <= page_next;
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

>>> rtl/lru_page_cache_tracker_top.sv
// ============================================================================
// lru_page_cache_tracker_top
// LRU residency tracker for a page cache of CACHE_ENTRIES slots.
//
// Input channel s_*: one beat per access (read, write) or evict command.
// Result channel m_*: exactly one beat per input beat, in order, carrying
// hit, fetch request, write-back page and the empty-cache error.
// Pages are kept in one memory ordered by recency rank; an access walks
// the list from the most recent rank, one memory read per cycle, shifting
// entries down as it goes; a hit ends the walk at its rank, a miss walks
// every used rank, and an evict reads only the last rank. One item is in
// work at a time; the next beat is accepted once the current result is
// parked.
// Reset empties the cache at once; the page memory needs no clearing.
// When the receiver stalls, one result waits in the output register and
// one more in the sequencer; input is then held off.
// ============================================================================
module lru_page_cache_tracker_top #(
    parameter int CACHE_ENTRIES = lpct_pkg::LPCT_CACHE_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lpct_pkg::lpct_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lpct_pkg::lpct_out_t  m_data
);
    import lpct_pkg::*;

    localparam int AW = $clog2(CACHE_ENTRIES);

    logic                   res_valid;
    logic                   res_ready;
    lpct_out_t              res;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [LPCT_PAGE_W-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [LPCT_PAGE_W-1:0] rd_data;
    logic                   m_valid_reg;
    lpct_out_t              m_data_reg;

    lpct_ctrl #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    lpct_page_ram #(
        .DEPTH(CACHE_ENTRIES)
    ) u_page_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> dv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the LRU page cache tracker: a recency-ordered
// shadow of the cache predicts every result beat, and directed plus random
// access/evict traffic runs with random idling on both channels.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpct_pkg::*;

    localparam int         SLOTS      = LPCT_CACHE_ENTRIES;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         IDLE_PCT   = 23;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lpct_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lpct_out_t m_data;

    // shadow of the cache contents
    logic [31:0] shadow_page [SLOTS];
    logic        shadow_valid[SLOTS];
    logic [3:0]  shadow_rank [SLOTS];
    logic [4:0]  shadow_count;

    lpct_out_t   cache_outcome_q[$];
    int          mismatch_count = 0;
    bit          no_idle        = 1'b0;
    logic [31:0] page_pool[$];

    lru_page_cache_tracker_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4ns aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic int oldest_slot();
        int best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && (best < 0 || shadow_rank[i] > shadow_rank[best]))
                best = i;
        end
        return best;
    endfunction

    // make slot s most recent; valid slots younger than limit age by one
    function automatic void make_most_recent(int s, int limit);
        for (int i = 0; i < SLOTS; i++) begin
            if (i != s && shadow_valid[i] && int'(shadow_rank[i]) < limit)
                shadow_rank[i] = shadow_rank[i] + 4'd1;
        end
        shadow_rank[s] = 4'd0;
    endfunction

    function automatic lpct_out_t lru_lookup(lpct_in_t beat);
        lpct_out_t res;
        int        found;
        int        s;
        res   = '0;
        found = -1;
        s     = -1;
        if (beat.command == CMD_EVICT) begin
            s = oldest_slot();
            if (s < 0 || shadow_count == 0) begin
                res.empty_error = 1'b1;
            end else begin
                res.writeback_valid = 1'b1;
                res.writeback_page  = shadow_page[s];
                shadow_valid[s]     = 1'b0;
                shadow_rank[s]      = 4'd0;
                shadow_count        = shadow_count - 5'd1;
            end
        end else if (beat.command == CMD_READ || beat.command == CMD_WRITE) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (found < 0 && shadow_valid[i] && shadow_page[i] == beat.page_number)
                    found = i;
            end
            if (found >= 0) begin
                res.hit = 1'b1;
                make_most_recent(found, int'(shadow_rank[found]));
            end else begin
                if (shadow_count < SLOTS) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (s < 0 && !shadow_valid[i])
                            s = i;
                    end
                end
                if (s >= 0) begin
                    shadow_valid[s] = 1'b1;
                    shadow_rank[s]  = 4'd0;
                    make_most_recent(s, SLOTS);
                    shadow_count    = shadow_count + 5'd1;
                end else begin
                    // full: reuse the least recent slot and report it
                    s = oldest_slot();
                    if (s < 0)
                        s = 0;
                    res.writeback_valid = 1'b1;
                    res.writeback_page  = shadow_page[s];
                    shadow_valid[s]     = 1'b1;
                    make_most_recent(s, int'(shadow_rank[s]));
                end
                shadow_page[s] = beat.page_number;
                if (beat.command == CMD_READ)
                    res.fetch_needed = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [31:0] page);
        lpct_in_t beat;
        beat.command     = cmd;
        beat.page_number = page;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cache_outcome_q.push_back(lru_lookup(beat));
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        lpct_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cache_outcome_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_data);
            end else begin
                want = cache_outcome_q.pop_front();
                compare_field("hit", 32'(want.hit), 32'(m_data.hit));
                compare_field("fetch_needed", 32'(want.fetch_needed),
                              32'(m_data.fetch_needed));
                compare_field("writeback_valid", 32'(want.writeback_valid),
                              32'(m_data.writeback_valid));
                compare_field("writeback_page", want.writeback_page,
                              m_data.writeback_page);
                compare_field("empty_error", 32'(want.empty_error),
                              32'(m_data.empty_error));
            end
        end
    end

    function automatic logic [1:0] pick_command();
        int r = $urandom_range(0, 99);
        if (r < 42)
            return CMD_READ;
        if (r < 82)
            return CMD_WRITE;
        if (r < 96)
            return CMD_EVICT;
        return CMD_UNUSED;
    endfunction

    function automatic logic [31:0] pick_page();
        if ($urandom_range(0, 99) < 8)
            return $urandom();
        return page_pool[$urandom_range(0, page_pool.size() - 1)];
    endfunction

    task automatic fill_pool(input int n);
        page_pool.delete();
        page_pool.push_back(32'h0000_0000);
        page_pool.push_back(32'hFFFF_FFFF);
        while (page_pool.size() < n)
            page_pool.push_back($urandom());
    endtask

    task automatic test_empty_and_unused();
        send_beat(CMD_EVICT, 32'h1234_5678);
        send_beat(CMD_UNUSED, 32'hFFFF_FFFF);
    endtask

    task automatic test_hit_and_miss();
        send_beat(CMD_READ, 32'h0000_0000);
        send_beat(CMD_WRITE, 32'hFFFF_FFFF);
        send_beat(CMD_READ, 32'h0000_0000);
        send_beat(CMD_WRITE, 32'hFFFF_FFFF);
        send_beat(CMD_EVICT, 32'hA5A5_A5A5);
    endtask

    task automatic test_full_cache();
        for (int i = 1; i < SLOTS; i++)
            send_beat(i[0] ? CMD_WRITE : CMD_READ, 32'(i));
        // one more miss on a full cache forces a write-back
        send_beat(CMD_READ, 32'd16);
    endtask

    task automatic test_random_traffic(input int n);
        fill_pool(40);
        for (int i = 0; i < n; i++) begin
            no_idle = (i >= 100 && i < 300);
            send_beat(pick_command(), pick_page());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_hot_set(input int n);
        fill_pool(14);
        for (int i = 0; i < n; i++)
            send_beat(pick_command(), pick_page());
    endtask

    task automatic test_drain();
        while (shadow_count != 0)
            send_beat(CMD_EVICT, $urandom());
        send_beat(CMD_EVICT, $urandom());
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            shadow_page[i]  = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 4'd0;
        end
        shadow_count = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_unused();
        test_hit_and_miss();
        test_full_cache();
        test_random_traffic(700);
        test_hot_set(450);
        test_drain();
        test_random_traffic(60);
        s_valid <= 1'b0;

        while (cache_outcome_q.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);

        if (mismatch_count == 0 && cache_outcome_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
rtl/lpct_pkg.sv
rtl/lpct_page_ram.sv
rtl/lpct_ctrl.sv
rtl/lru_page_cache_tracker_top.sv
dv/tb_top.sv
